// ----- hw/rtl/scf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

    // field widths, fixed by the register map and the word format
    localparam int AMP_W    = 13;
    localparam int EDGE_W   = 8;
    localparam int COUNT_W  = 10;
    localparam int WCUT_W   = 9;
    localparam int CHARGE_W = 21;
    localparam int STRIP_W  = 10;
    localparam int PEAK_W   = 12;
    localparam int MOMENT_W = 30;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_ZS_LEVEL    = 3'd0;
    localparam logic [2:0] REG_EDGE_SKIP   = 3'd1;
    localparam logic [2:0] REG_STRIP_COUNT = 3'd2;
    localparam logic [2:0] REG_MIN_SPREAD  = 3'd3;
    localparam logic [2:0] REG_MIN_CHARGE  = 3'd4;

    localparam logic signed [AMP_W-1:0] ZS_LEVEL_RST    = 13'sd0;
    localparam logic [EDGE_W-1:0]       EDGE_SKIP_RST   = 8'd0;
    localparam logic [COUNT_W-1:0]      STRIP_COUNT_RST = 10'd512;
    localparam logic [WCUT_W-1:0]       MIN_SPREAD_RST  = 9'd0;
    localparam logic [CHARGE_W-1:0]     MIN_CHARGE_RST  = 21'd1000;

    localparam logic [CHARGE_W-1:0] CHARGE_MAX = {CHARGE_W{1'b1}};
    localparam logic [MOMENT_W-1:0] MOMENT_MAX = {MOMENT_W{1'b1}};

    typedef struct packed {
        logic signed [AMP_W-1:0] zs_level;
        logic [EDGE_W-1:0]       edge_skip;
        logic [COUNT_W-1:0]      strip_count;
        logic [WCUT_W-1:0]       min_spread;
        logic [CHARGE_W-1:0]     min_charge;
    } t_cfg;

    typedef struct packed {
        logic [STRIP_W-1:0]  first_strip;
        logic [STRIP_W-1:0]  last_strip;
        logic [CHARGE_W-1:0] charge;
        logic [PEAK_W-1:0]   peak;
        logic [MOMENT_W-1:0] moment;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/scf_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scf_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [scf_pkg::APB_AW-1:0]  paddr,
    input  wire logic [scf_pkg::APB_DW-1:0]  pwdata,
    output logic      [scf_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output scf_pkg::t_cfg                    o_cfg
);

    scf_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zs_level    <= scf_pkg::ZS_LEVEL_RST;
            r_cfg.edge_skip   <= scf_pkg::EDGE_SKIP_RST;
            r_cfg.strip_count <= scf_pkg::STRIP_COUNT_RST;
            r_cfg.min_spread  <= scf_pkg::MIN_SPREAD_RST;
            r_cfg.min_charge  <= scf_pkg::MIN_CHARGE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                scf_pkg::REG_ZS_LEVEL: begin
                    r_cfg.zs_level <= $signed(pwdata[scf_pkg::AMP_W-1:0]);
                end
                scf_pkg::REG_EDGE_SKIP: begin
                    r_cfg.edge_skip <= pwdata[scf_pkg::EDGE_W-1:0];
                end
                scf_pkg::REG_STRIP_COUNT: begin
                    r_cfg.strip_count <= pwdata[scf_pkg::COUNT_W-1:0];
                end
                scf_pkg::REG_MIN_SPREAD: begin
                    r_cfg.min_spread <= pwdata[scf_pkg::WCUT_W-1:0];
                end
                scf_pkg::REG_MIN_CHARGE: begin
                    r_cfg.min_charge <= pwdata[scf_pkg::CHARGE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            scf_pkg::REG_ZS_LEVEL:
                prdata = scf_pkg::APB_DW'(unsigned'(r_cfg.zs_level));
            scf_pkg::REG_EDGE_SKIP:   prdata = scf_pkg::APB_DW'(r_cfg.edge_skip);
            scf_pkg::REG_STRIP_COUNT: prdata = scf_pkg::APB_DW'(r_cfg.strip_count);
            scf_pkg::REG_MIN_SPREAD:  prdata = scf_pkg::APB_DW'(r_cfg.min_spread);
            scf_pkg::REG_MIN_CHARGE:  prdata = scf_pkg::APB_DW'(r_cfg.min_charge);
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/scf_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scf_core #(
    parameter int MAX_STRIPS = 512,
    parameter int ADC_BITS   = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_advance,
    input  wire logic signed [scf_pkg::AMP_W-1:0]  i_amplitude,
    input  scf_pkg::t_cfg                          i_cfg,
    output logic                                   o_res_valid,
    output scf_pkg::t_result                       o_res
);

    // strip numbers never exceed the clamped count, which the 10 bit register caps
    localparam int CLAMP = (MAX_STRIPS < 1023) ? MAX_STRIPS : 1023;
    localparam int IDX_W = $clog2(CLAMP + 1);
    localparam int V_W   = (ADC_BITS < scf_pkg::PEAK_W) ? ADC_BITS : scf_pkg::PEAK_W;
    localparam int CW    = ((IDX_W > scf_pkg::WCUT_W) ? IDX_W : scf_pkg::WCUT_W) + 1;
    localparam int VSAT  = (1 << V_W) - 1;
    localparam int PROD_W = V_W + IDX_W;

    logic [IDX_W-1:0]              r_index, n_index;
    logic                          r_in_cluster, n_in_cluster;
    logic [IDX_W-1:0]              r_start, n_start;
    logic [scf_pkg::CHARGE_W-1:0]  r_charge, n_charge;
    logic [V_W-1:0]                r_peak, n_peak;
    logic [scf_pkg::MOMENT_W-1:0]  r_moment, n_moment;
    logic [V_W-1:0]                r_held_value, n_held_value;
    logic                          r_held_valid, n_held_valid;

    logic [scf_pkg::COUNT_W-1:0]   count_cl;
    logic [IDX_W-1:0]              count;
    logic [IDX_W-1:0]              strip_no;
    logic [CW-1:0]                 win_end;
    logic                          in_win;
    logic                          at_end;
    logic [V_W-1:0]                val;
    logic                          val_pos;
    logic                          pending;
    logic                          close_held;
    logic                          close_here;
    logic                          do_close;
    logic                          grow;
    logic [IDX_W-1:0]              eff_start;
    logic [IDX_W-1:0]              last;
    logic [scf_pkg::CHARGE_W-1:0]  base_charge;
    logic [V_W-1:0]                base_peak;
    logic [scf_pkg::MOMENT_W-1:0]  base_moment;
    logic [scf_pkg::CHARGE_W:0]    charge_add;
    logic [PROD_W-1:0]             prod;
    logic [scf_pkg::MOMENT_W:0]    moment_sum;
    logic [scf_pkg::CHARGE_W-1:0]  upd_charge;
    logic [V_W-1:0]                upd_peak;
    logic [scf_pkg::MOMENT_W-1:0]  upd_moment;
    logic                          keep;

    // clamp the strip count and derive the search window
    always_comb begin
        if (i_cfg.strip_count == '0) begin
            count_cl = scf_pkg::COUNT_W'(1);
        end else if (i_cfg.strip_count > scf_pkg::COUNT_W'(CLAMP)) begin
            count_cl = scf_pkg::COUNT_W'(CLAMP);
        end else begin
            count_cl = i_cfg.strip_count;
        end
        count    = count_cl[IDX_W-1:0];
        strip_no = r_index + 1'b1;
        win_end  = (CW'(count) > CW'(i_cfg.edge_skip)) ?
                   CW'(count) - CW'(i_cfg.edge_skip) : '0;
        in_win   = (CW'(strip_no) > CW'(i_cfg.edge_skip)) && (CW'(strip_no) <= win_end);
        at_end   = (CW'(strip_no) == win_end);
    end

    // zero suppression, negative values count as zero, saturate at the ADC range
    always_comb begin
        val = '0;
        if (($signed(i_amplitude) > $signed(i_cfg.zs_level)) &&
            ($signed(i_amplitude) > $signed(scf_pkg::AMP_W'(0)))) begin
            if (i_amplitude[scf_pkg::AMP_W-2:0] > (scf_pkg::AMP_W-1)'(VSAT)) begin
                val = V_W'(VSAT);
            end else begin
                val = i_amplitude[V_W-1:0];
            end
        end
        val_pos = (val != '0);
    end

    // close decisions and accumulator update
    always_comb begin
        pending    = r_in_cluster && r_held_valid && (r_held_value == '0);
        close_held = pending && (!in_win || !val_pos);
        close_here = in_win && at_end && (val_pos || (r_in_cluster && !close_held));
        do_close   = close_held || close_here;
        grow       = in_win && val_pos;

        eff_start   = r_in_cluster ? r_start : strip_no;
        base_charge = r_in_cluster ? r_charge : '0;
        base_peak   = r_in_cluster ? r_peak : '0;
        base_moment = r_in_cluster ? r_moment : '0;

        charge_add = {1'b0, base_charge} + (scf_pkg::CHARGE_W+1)'(val);
        prod       = PROD_W'(val) * PROD_W'(strip_no);
        moment_sum = {1'b0, base_moment} + (scf_pkg::MOMENT_W+1)'(prod);

        if (grow) begin
            upd_charge = charge_add[scf_pkg::CHARGE_W] ? scf_pkg::CHARGE_MAX :
                         charge_add[scf_pkg::CHARGE_W-1:0];
            upd_peak   = (val > base_peak) ? val : base_peak;
            upd_moment = moment_sum[scf_pkg::MOMENT_W] ? scf_pkg::MOMENT_MAX :
                         moment_sum[scf_pkg::MOMENT_W-1:0];
        end else begin
            upd_charge = base_charge;
            upd_peak   = base_peak;
            upd_moment = base_moment;
        end

        last = close_held ? (strip_no - 1'b1) : strip_no;
        keep = (last >= eff_start) &&
               ((CW'(last) - CW'(eff_start)) > CW'(i_cfg.min_spread)) &&
               (upd_charge > i_cfg.min_charge);

        o_res_valid       = do_close && keep;
        o_res.first_strip = scf_pkg::STRIP_W'(eff_start);
        o_res.last_strip  = scf_pkg::STRIP_W'(last);
        o_res.charge      = upd_charge;
        o_res.peak        = scf_pkg::PEAK_W'(upd_peak);
        o_res.moment      = upd_moment;
    end

    // next state
    always_comb begin
        n_index      = strip_no;
        n_in_cluster = r_in_cluster;
        n_start      = r_start;
        n_charge     = r_charge;
        n_peak       = r_peak;
        n_moment     = r_moment;
        n_held_value = val;
        n_held_valid = in_win;
        if (do_close) begin
            n_in_cluster = 1'b0;
            n_start      = '0;
            n_charge     = '0;
            n_peak       = '0;
            n_moment     = '0;
        end else if (grow) begin
            n_in_cluster = 1'b1;
            n_start      = eff_start;
            n_charge     = upd_charge;
            n_peak       = upd_peak;
            n_moment     = upd_moment;
        end
        // event end: restart numbering, drop any open cluster
        if (strip_no >= count) begin
            n_index      = '0;
            n_in_cluster = 1'b0;
            n_start      = '0;
            n_charge     = '0;
            n_peak       = '0;
            n_moment     = '0;
            n_held_value = '0;
            n_held_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index      <= '0;
            r_in_cluster <= 1'b0;
            r_start      <= '0;
            r_charge     <= '0;
            r_peak       <= '0;
            r_moment     <= '0;
            r_held_value <= '0;
            r_held_valid <= 1'b0;
        end else if (i_advance) begin
            r_index      <= n_index;
            r_in_cluster <= n_in_cluster;
            r_start      <= n_start;
            r_charge     <= n_charge;
            r_peak       <= n_peak;
            r_moment     <= n_moment;
            r_held_value <= n_held_value;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/strip_cluster_finder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Strip cluster finder. Takes one strip amplitude word per clock, in strip
// order, strip_count strips per event, and emits one cluster word whenever a
// cluster closes and passes the width and charge cuts. Sustained rate is one
// strip per cycle unless the input side stalls; a strip passes through an
// input register, then the suppression, window and accumulator logic, and its
// cluster word (if any) lands in the output register when the strip moves on
// from the input register. The input side stalls only when a new cluster word
// is ready while the previous one is still held by a stalled output. The user
// writes the registers over the APB port only while the stream is idle; the
// block itself does not enforce it.
module strip_cluster_finder #(
    parameter int MAX_STRIPS = 512,
    parameter int ADC_BITS   = 12
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // strip word in
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [scf_pkg::AMP_W-1:0]    i_amplitude,
    // cluster word out
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [scf_pkg::STRIP_W-1:0]              o_first_strip,
    output logic [scf_pkg::STRIP_W-1:0]              o_last_strip,
    output logic [scf_pkg::CHARGE_W-1:0]             o_charge,
    output logic [scf_pkg::PEAK_W-1:0]               o_peak,
    output logic [scf_pkg::MOMENT_W-1:0]             o_moment,
    // APB register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [scf_pkg::APB_AW-1:0]          paddr,
    input  wire logic [scf_pkg::APB_DW-1:0]          pwdata,
    output logic      [scf_pkg::APB_DW-1:0]          prdata,
    output logic                                     pready
);

    scf_pkg::t_cfg    cfg;
    scf_pkg::t_result res;
    logic             res_valid;
    logic             advance;

    logic                            r_in_valid;
    logic signed [scf_pkg::AMP_W-1:0] r_amp;
    logic                            r_out_valid;
    scf_pkg::t_result                r_out;

    scf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    scf_core #(
        .MAX_STRIPS (MAX_STRIPS),
        .ADC_BITS   (ADC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_amplitude (r_amp),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // A held strip moves on unless it makes a word and the output slot is
    // occupied and stalled. Strips that make no word never wait.
    assign advance = r_in_valid && (!res_valid || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_amp <= i_amplitude;
        end
    end

    // output register: cleared when taken, refilled by a closing strip
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_first_strip = r_out.first_strip;
    assign o_last_strip  = r_out.last_strip;
    assign o_charge      = r_out.charge;
    assign o_peak        = r_out.peak;
    assign o_moment      = r_out.moment;

endmodule

`default_nettype wire

// ----- tb/scf_cluster_checker.sv -----
`timescale 1ns / 1ps

// Watches the strip and cluster channels and the APB port, keeps its own copy of
// the finder state and register set, and checks every cluster word against the
// oldest outstanding prediction.
module scf_cluster_checker #(
    parameter int MAX_STRIPS = 512,
    parameter int ADC_BITS   = 12
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_strip_valid,
    input  wire logic                                i_strip_stall,
    input  wire logic signed [scf_pkg::AMP_W-1:0]    i_amplitude,
    input  wire logic                                i_cl_valid,
    input  wire logic                                i_cl_stall,
    input  wire logic [scf_pkg::STRIP_W-1:0]         i_first_strip,
    input  wire logic [scf_pkg::STRIP_W-1:0]         i_last_strip,
    input  wire logic [scf_pkg::CHARGE_W-1:0]        i_charge,
    input  wire logic [scf_pkg::PEAK_W-1:0]          i_peak,
    input  wire logic [scf_pkg::MOMENT_W-1:0]        i_moment,
    input  wire logic                                i_psel,
    input  wire logic                                i_penable,
    input  wire logic                                i_pwrite,
    input  wire logic                                i_pready,
    input  wire logic [scf_pkg::APB_AW-1:0]          i_paddr,
    input  wire logic [scf_pkg::APB_DW-1:0]          i_pwdata,
    output int                                       o_fail_count,
    output int                                       o_pending,
    output int                                       o_strips_taken,
    output int                                       o_clusters_checked
);
    import scf_pkg::*;

    localparam int ADC_MAX     = (1 << ADC_BITS) - 1;
    localparam int REPORT_CAP  = 10;

    t_cfg    cfg;
    t_result expected_clusters[$];

    // finder state
    logic [COUNT_W-1:0]  strip_idx;
    logic                in_cluster;
    logic [STRIP_W-1:0]  cluster_first;
    logic [CHARGE_W-1:0] charge_acc;
    logic [PEAK_W-1:0]   peak_max;
    logic [MOMENT_W-1:0] moment_sum;
    logic [PEAK_W-1:0]   prev_val;
    logic                prev_in_win;

    function automatic string show(input t_result r);
        return $sformatf("first %0d last %0d charge %0d peak %0d moment %0d",
                         r.first_strip, r.last_strip, r.charge, r.peak, r.moment);
    endfunction

    function automatic void log_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_CAP)
            $display("[%0t] cluster check failed: %s", $realtime, msg);
    endfunction

    function automatic void clear_cluster();
        in_cluster    = 1'b0;
        cluster_first = '0;
        charge_acc    = '0;
        peak_max      = '0;
        moment_sum    = '0;
    endfunction

    function automatic void close_cluster(input int last);
        int      first;
        t_result r;
        first = cluster_first;
        if (last >= first && last - first > int'(cfg.min_spread) &&
            charge_acc > cfg.min_charge) begin
            r.first_strip = STRIP_W'(first);
            r.last_strip  = STRIP_W'(last);
            r.charge      = charge_acc;
            r.peak        = peak_max;
            r.moment      = moment_sum;
            expected_clusters = {expected_clusters, r};
        end
        clear_cluster();
    endfunction

    // one strip through suppression, window and cluster logic
    function automatic void fold_strip(input logic signed [AMP_W-1:0] amp);
        int     a, thr, count, n, win_lo, win_hi, v, sum;
        longint m;
        bit     in_win;
        a     = amp;
        thr   = $signed(cfg.zs_level);
        count = cfg.strip_count;
        if (count == 0) count = 1;
        if (count > MAX_STRIPS) count = MAX_STRIPS;

        n      = int'(strip_idx) + 1;
        win_lo = int'(cfg.edge_skip) + 1;
        win_hi = (count > int'(cfg.edge_skip)) ? count - int'(cfg.edge_skip) : 0;
        in_win = (n >= win_lo) && (n <= win_hi);

        v = 0;
        if (a > thr && a > 0) v = (a > ADC_MAX) ? ADC_MAX : a;

        // pending zero strip: closes unless the next strip bridges it
        if (in_cluster && prev_in_win && prev_val == '0 && (!in_win || v == 0))
            close_cluster(n - 1);

        if (in_win) begin
            if (v > 0) begin
                if (!in_cluster) begin
                    clear_cluster();
                    in_cluster    = 1'b1;
                    cluster_first = STRIP_W'(n);
                end
                sum        = int'(charge_acc) + v;
                charge_acc = (sum > int'(CHARGE_MAX)) ? CHARGE_MAX : CHARGE_W'(sum);
                if (v > int'(peak_max)) peak_max = PEAK_W'(v);
                m          = longint'(moment_sum) + longint'(v) * n;
                moment_sum = (m > longint'(MOMENT_MAX)) ? MOMENT_MAX : MOMENT_W'(m);
                if (n == win_hi) close_cluster(n);
            end else if (in_cluster && n == win_hi) begin
                close_cluster(n);
            end
        end

        prev_val    = PEAK_W'(v);
        prev_in_win = in_win;

        if (n >= count) begin
            strip_idx = '0;
            clear_cluster();
            prev_val    = '0;
            prev_in_win = 1'b0;
        end else begin
            strip_idx = COUNT_W'(n);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            cfg.zs_level    = ZS_LEVEL_RST;
            cfg.edge_skip   = EDGE_SKIP_RST;
            cfg.strip_count = STRIP_COUNT_RST;
            cfg.min_spread  = MIN_SPREAD_RST;
            cfg.min_charge  = MIN_CHARGE_RST;
            expected_clusters.delete();
            strip_idx   = '0;
            clear_cluster();
            prev_val    = '0;
            prev_in_win = 1'b0;
            o_fail_count       = 0;
            o_strips_taken     = 0;
            o_clusters_checked = 0;
        end else begin
            // words leaving now were caused by strips taken earlier
            if (i_cl_valid === 1'b1 && i_cl_stall === 1'b0) begin
                got.first_strip = i_first_strip;
                got.last_strip  = i_last_strip;
                got.charge      = i_charge;
                got.peak        = i_peak;
                got.moment      = i_moment;
                if (expected_clusters.size() == 0) begin
                    log_mismatch({"cluster word with none expected: ", show(got)});
                end else begin
                    want = expected_clusters.pop_front();
                    if (got.first_strip !== want.first_strip ||
                        got.last_strip  !== want.last_strip  ||
                        got.charge      !== want.charge      ||
                        got.peak        !== want.peak        ||
                        got.moment      !== want.moment)
                        log_mismatch({"expected ", show(want), ", got ", show(got)});
                    o_clusters_checked++;
                end
            end

            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_AW-1:2])
                    REG_ZS_LEVEL:    cfg.zs_level    = i_pwdata[AMP_W-1:0];
                    REG_EDGE_SKIP:   cfg.edge_skip   = i_pwdata[EDGE_W-1:0];
                    REG_STRIP_COUNT: cfg.strip_count = i_pwdata[COUNT_W-1:0];
                    REG_MIN_SPREAD:  cfg.min_spread  = i_pwdata[WCUT_W-1:0];
                    REG_MIN_CHARGE:  cfg.min_charge  = i_pwdata[CHARGE_W-1:0];
                    default: ;
                endcase
            end

            if (i_strip_valid === 1'b1 && i_strip_stall === 1'b0) begin
                fold_strip(i_amplitude);
                o_strips_taken++;
            end
        end
        o_pending = expected_clusters.size();
    end

endmodule

// ----- tb/tb_strip_cluster_finder.sv -----
`timescale 1ns / 1ps

// Drives strip words into the cluster finder, stalls its cluster output at
// random and reprogrammes the cut registers between phases. All checking
// happens in the checker beside the DUT; this module only makes stimulus and
// gives the verdict.
module tb_strip_cluster_finder;
    import scf_pkg::*;

    localparam int MAX_STRIPS    = 512;
    localparam int ADC_BITS      = 12;
    localparam int RANDOM_STRIPS = 1650;
    localparam int PHASES        = 10;
    localparam int HOLD_CYCLES   = 400;   // long output hold, fills the pipe
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int AMP_MAX       = (1 << (AMP_W - 1)) - 1;
    localparam int AMP_MIN       = -(1 << (AMP_W - 1));

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic signed [AMP_W-1:0]  i_amplitude = '0;
    logic                     i_stall     = 1'b0;
    logic                     psel        = 1'b0;
    logic                     penable     = 1'b0;
    logic                     pwrite      = 1'b0;
    logic [APB_AW-1:0]        paddr       = '0;
    logic [APB_DW-1:0]        pwdata      = '0;

    logic                     o_stall;
    logic                     o_valid;
    logic [STRIP_W-1:0]       o_first_strip;
    logic [STRIP_W-1:0]       o_last_strip;
    logic [CHARGE_W-1:0]      o_charge;
    logic [PEAK_W-1:0]        o_peak;
    logic [MOMENT_W-1:0]      o_moment;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    int fail_count, pending, strips_taken, clusters_checked;

    // knobs and counters of the stimulus; stall_on and hold_req steer the stall process
    int  zs_now         = 0;
    int  strips_sent    = 0;
    int  settings_used  = 0;
    int  cycles         = 0;
    bit  gaps_on        = 1'b1;
    bit  stall_on       = 1'b1;
    bit  hold_req       = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    strip_cluster_finder #(
        .MAX_STRIPS (MAX_STRIPS),
        .ADC_BITS   (ADC_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_amplitude   (i_amplitude),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_first_strip (o_first_strip),
        .o_last_strip  (o_last_strip),
        .o_charge      (o_charge),
        .o_peak        (o_peak),
        .o_moment      (o_moment),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    scf_cluster_checker #(
        .MAX_STRIPS (MAX_STRIPS),
        .ADC_BITS   (ADC_BITS)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_strip_valid      (i_valid),
        .i_strip_stall      (o_stall),
        .i_amplitude        (i_amplitude),
        .i_cl_valid         (o_valid),
        .i_cl_stall         (i_stall),
        .i_first_strip      (o_first_strip),
        .i_last_strip       (o_last_strip),
        .i_charge           (o_charge),
        .i_peak             (o_peak),
        .i_moment           (o_moment),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_pready           (pready),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_strips_taken     (strips_taken),
        .o_clusters_checked (clusters_checked)
    );

    // mostly back to back, now and then a long pause
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // a strip that suppresses to zero: at or below the level, or not positive
    function automatic int quiet_amp();
        int hi, span;
        hi   = (zs_now > 0) ? zs_now : 0;
        span = hi - AMP_MIN;
        if ($urandom_range(0, 1)) return int'($urandom_range(0, span)) + AMP_MIN;
        return hi - int'($urandom_range(0, (span < 60) ? span : 60));
    endfunction

    // a strip that survives suppression where the level allows, mostly near the level
    function automatic int hot_amp();
        int lo;
        lo = ((zs_now > 0) ? zs_now : 0) + 1;
        if (lo > AMP_MAX) return AMP_MAX;
        if ($urandom_range(0, 9) == 0) return $urandom_range(lo, AMP_MAX);
        return $urandom_range(lo, (lo + 700 > AMP_MAX) ? AMP_MAX : lo + 700);
    endfunction

    // one strip word; called and returns at a falling edge, payload held while stalled
    task automatic send_strip(input int amp);
        int gap;
        gap = gaps_on ? gap_len() : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_amplitude = AMP_W'(amp);
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        strips_sent++;
        @(negedge i_clk);
    endtask

    // stream idle, every predicted word out, pipe flushed
    task automatic settle();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        if (idx == REG_ZS_LEVEL) zs_now = value;
    endtask

    task automatic apply_settings(input int zs_lvl, input int edge_strips,
                                  input int n_strips, input int min_spread,
                                  input int charge_cut);
        settle();
        write_reg(REG_ZS_LEVEL, zs_lvl);
        write_reg(REG_EDGE_SKIP, edge_strips);
        write_reg(REG_STRIP_COUNT, n_strips);
        write_reg(REG_MIN_SPREAD, min_spread);
        write_reg(REG_MIN_CHARGE, charge_cut);
        settings_used++;
    endtask

    task automatic random_settings();
        int zs_lvl, n_strips;
        zs_lvl = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 8191)) + AMP_MIN
                                             : int'($urandom_range(0, 700)) - 200;
        n_strips = ($urandom_range(0, 9) != 0) ? $urandom_range(8, 64)
                                               : $urandom_range(65, 1023);
        apply_settings(zs_lvl, $urandom_range(0, 6), n_strips, $urandom_range(0, 3),
                       $urandom_range(0, 2500));
    endtask

    // clusters of hot strips with the odd single or double quiet strip inside,
    // quiet runs between them, and full-range noise now and then
    task automatic send_stream(input int n_items);
        int goal, len;
        goal = strips_sent + n_items;
        while (strips_sent < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                send_strip(int'($urandom_range(0, 8191)) + AMP_MIN);
            end else begin
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++) begin
                    if (j > 0 && $urandom_range(0, 6) == 0) begin
                        send_strip(quiet_amp());
                        if ($urandom_range(0, 3) == 0) send_strip(quiet_amp());
                    end
                    send_strip(hot_amp());
                end
                repeat ($urandom_range(1, 4)) send_strip(quiet_amp());
            end
        end
    endtask

    // output side: random stall spans, one long hold on request
    initial begin
        int span;
        bit hold;
        forever begin
            if (hold_req) begin
                hold     = 1'b1;
                span     = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                hold = stall_on && ($urandom_range(0, 99) < 30);
                span = hold ? gap_len() + 1 : $urandom_range(1, 12);
            end
            @(negedge i_clk);
            i_stall = hold;
            repeat (span - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d cluster words outstanding",
                     cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        // bridges, a pending zero closed by a second zero, and one left
        // pending for the window move below
        int opening[13] = '{4095, -4096, 500, 50, 600, 0, -1, 300, 4095, 7,
                            2000, 3000, 0};
        // with a negative level: a kept negative strip counts as zero
        int below_zero[6] = '{0, 0, -10, 200, -20, -30};

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        apply_settings(100, 2, 24, 0, 0);
        foreach (opening[k]) send_strip(opening[k]);
        // shrink the window under the pending zero: next strip falls outside
        settle();
        write_reg(REG_EDGE_SKIP, 12);
        send_strip(800);
        settle();
        write_reg(REG_EDGE_SKIP, 2);
        send_strip(900);
        send_strip(900);
        // cut the event short with a cluster open: it is dropped
        settle();
        write_reg(REG_STRIP_COUNT, 10);
        send_strip(700);
        settle();
        write_reg(REG_ZS_LEVEL, -50);
        write_reg(REG_STRIP_COUNT, 24);
        foreach (below_zero[k]) send_strip(below_zero[k]);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_settings(AMP_MIN, 0, 512, 0, 0);
                // nothing survives, empty window, count of zero
                1: apply_settings(AMP_MAX, 255, 0, 511, int'(CHARGE_MAX));
                // count above the plane size
                2: apply_settings(int'($urandom_range(0, 300)), 100, 1023, 0, 500);
                // edge margin eats the whole plane
                3: apply_settings(int'($urandom_range(0, 300)) - 100, 40, 30, 1, 0);
                default: random_settings();
            endcase
            gaps_on  = (p != 6) && (p != 7);
            stall_on = (p != 7);
            if (p == 6) hold_req = 1'b1;
            send_stream(RANDOM_STRIPS / PHASES);
        end
        settle();

        $display("run: %0d strip words through %0d register settings, %0d cluster words checked",
                 strips_taken, settings_used, clusters_checked);
        $display("incl. plane-edge windows, out-of-range counts, bridging and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/scf_pkg.sv
hw/rtl/scf_regs.sv
hw/rtl/scf_core.sv
hw/rtl/strip_cluster_finder.sv
tb/scf_cluster_checker.sv
tb/tb_strip_cluster_finder.sv
